// ----- hw/rtl/drt_pkg.sv -----
// Shared constants, types and checksum helper for the DNS truncation reflector.
`default_nettype none

package drt_pkg;

    // Window and tag limits
    localparam int HDR_WORDS     = 16;
    localparam int MAX_VLAN_TAGS = 2;

    // Derived widths
    localparam int ADDR_W = $clog2(HDR_WORDS);
    localparam int CNT_W  = $clog2(HDR_WORDS + 2);
    localparam int LEN_W  = $clog2(HDR_WORDS * 8 + 1);
    localparam int SUM_W  = LEN_W + 1;
    localparam int TAG_W  = $clog2(MAX_VLAN_TAGS + 2);
    localparam int RAM_W  = 68;

    // Command queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    // Verdicts
    localparam logic [1:0] V_DROP = 2'd0;
    localparam logic [1:0] V_PASS = 2'd1;
    localparam logic [1:0] V_TX   = 2'd2;

    // Protocol numbers
    localparam logic [15:0] ET_VLAN = 16'h8100;
    localparam logic [15:0] ET_QINQ = 16'h88A8;
    localparam logic [15:0] ET_IPV4 = 16'h0800;
    localparam logic [15:0] ET_IPV6 = 16'h86DD;
    localparam logic [7:0]  IP_UDP  = 8'd17;

    // Configuration registers
    localparam int         CFG_IDX_W      = 1;
    localparam logic [0:0] CFG_MATCH_PORT = 1'd0;
    localparam logic [0:0] CFG_REPLY_TTL  = 1'd1;
    localparam logic [15:0] MATCH_PORT_RST = 16'd53;
    localparam logic [7:0]  REPLY_TTL_RST  = 8'd64;

    // One buffered word with its valid byte count
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  vb;
    } t_word;

    // Command from the front end: a closed window or a pass-through word
    typedef struct packed {
        logic             win;
        logic [63:0]      word;
        logic [3:0]       vb;
        logic             last;
        logic [CNT_W-1:0] n;
        logic [LEN_W-1:0] len;
    } t_cmd;

    // Incremental ones-complement checksum update (RFC 1624 form)
    function automatic logic [15:0] csum_patch(input logic [15:0] csum,
                                               input logic [15:0] from,
                                               input logic [15:0] to);
        logic [17:0] s;
        logic [16:0] t;
        logic [16:0] u;
        logic [15:0] r;
        s = {2'b00, ~csum} + {2'b00, ~from} + {2'b00, to} + 18'd1;
        t = {1'b0, s[15:0]} + 17'h0FFFE + {16'd0, s[16]};
        u = {1'b0, t[15:0]} + {16'd0, t[16]};
        if (s[17]) begin
            r = 16'(s - 18'h1FFFF);
        end else begin
            r = u[15:0];
        end
        return ~r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/drt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module drt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_ren,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ren) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/drt_front.sv -----
// Front end: accepts packet words, fills the header buffer, issues commands.
`default_nettype none

module drt_front import drt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [63:0]       i_word_bytes,
    input  wire logic [3:0]        i_valid_bytes,
    input  wire logic              i_last_word,
    input  wire logic              i_q_full,
    output logic                   o_q_push,
    output t_cmd                   o_q_cmd,
    output logic                   o_ram_we,
    output logic [ADDR_W-1:0]      o_ram_waddr,
    output logic [RAM_W-1:0]       o_ram_wdata,
    input  wire logic              i_win_done
);

    logic [CNT_W-1:0] r_count;
    logic [LEN_W-1:0] r_len;
    logic             r_short;
    logic             r_busy;

    logic             accept;
    logic             passing;
    logic [3:0]       vb;
    logic [LEN_W-1:0] len_sum;
    logic [CNT_W-1:0] count_inc;
    logic             close_win;

    // Clamp valid byte count to 1..8
    always_comb begin
        if (i_valid_bytes == 4'd0) begin
            vb = 4'd1;
        end else if (i_valid_bytes > 4'd8) begin
            vb = 4'd8;
        end else begin
            vb = i_valid_bytes;
        end
    end

    assign passing    = (r_count == CNT_W'(HDR_WORDS));
    assign o_in_stall = i_q_full || (!passing && r_busy);
    assign accept     = i_in_valid && !o_in_stall;
    assign count_inc  = r_count + CNT_W'(1);
    assign len_sum    = r_short ? r_len : r_len + LEN_W'(vb);
    assign close_win  = i_last_word || (count_inc == CNT_W'(HDR_WORDS));

    // Buffer write
    assign o_ram_we    = accept && !passing;
    assign o_ram_waddr = r_count[ADDR_W-1:0];
    assign o_ram_wdata = {i_word_bytes, vb};

    // Command out
    assign o_q_push = accept && (passing || close_win);
    always_comb begin
        o_q_cmd.win  = !passing;
        o_q_cmd.word = i_word_bytes;
        o_q_cmd.vb   = vb;
        o_q_cmd.last = i_last_word;
        o_q_cmd.n    = count_inc;
        o_q_cmd.len  = len_sum;
    end

    // Window tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_len   <= '0;
            r_short <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            if (i_win_done) begin
                r_busy <= 1'b0;
            end
            if (accept) begin
                if (passing) begin
                    if (i_last_word) begin
                        r_count <= '0;
                    end
                end else if (close_win) begin
                    r_busy  <= 1'b1;
                    r_count <= i_last_word ? '0 : CNT_W'(HDR_WORDS);
                    r_len   <= '0;
                    r_short <= 1'b0;
                end else begin
                    r_count <= count_inc;
                    r_len   <= len_sum;
                    r_short <= r_short || (vb < 4'd8);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/drt_queue.sv -----
// Short command queue between the front end and the back end.
`default_nettype none

module drt_queue import drt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_empty
);

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_head;
    logic [QPTR_W-1:0] r_tail;
    logic [QPTR_W:0]   r_used;

    assign o_full  = (r_used == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_used == '0);
    assign o_cmd   = r_slot[r_head];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_tail] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_used <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + QPTR_W'(1);
            end
            if (i_pop) begin
                r_head <= r_head + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_used <= r_used + (QPTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_used <= r_used - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/drt_back.sv -----
// Back end: parses a closed window, rewrites replies and drives the output.
`default_nettype none

module drt_back import drt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  t_cmd                   i_q_cmd,
    input  wire logic              i_q_empty,
    output logic                   o_q_pop,
    output logic                   o_ram_ren,
    output logic [ADDR_W-1:0]      o_ram_raddr,
    input  wire logic [RAM_W-1:0]  i_ram_rdata,
    input  wire logic [15:0]       i_match_port,
    input  wire logic [7:0]        i_reply_ttl,
    output logic                   o_win_done,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [63:0]            o_out_word,
    output logic [3:0]             o_out_valid_bytes,
    output logic                   o_out_last,
    output logic [1:0]             o_verdict
);

    // Sequencer states
    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_FRD0  = 4'd1;
    localparam logic [3:0] B_FRD1  = 4'd2;
    localparam logic [3:0] B_FEVAL = 4'd3;
    localparam logic [3:0] B_ROUTE = 4'd4;
    localparam logic [3:0] B_L4    = 4'd5;
    localparam logic [3:0] B_CS    = 4'd6;
    localparam logic [3:0] B_ORD   = 4'd7;
    localparam logic [3:0] B_OSH   = 4'd8;

    // Meaning of the fetched bytes
    localparam logic [2:0] ST_ETYPE = 3'd0;
    localparam logic [2:0] ST_TAG   = 3'd1;
    localparam logic [2:0] ST_V4A   = 3'd2;
    localparam logic [2:0] ST_V4B   = 3'd3;
    localparam logic [2:0] ST_V6    = 3'd4;
    localparam logic [2:0] ST_UDP   = 3'd5;
    localparam logic [2:0] ST_DNS   = 3'd6;

    logic [3:0]       r_state, n_state;
    logic [2:0]       r_step;
    logic [LEN_W-1:0] r_faddr;
    logic [63:0]      r_flo;
    logic [CNT_W-1:0] r_n;
    logic [LEN_W-1:0] r_len;
    logic             r_last;
    logic [15:0]      r_proto;
    logic [LEN_W-1:0] r_off;
    logic [TAG_W-1:0] r_tags;
    logic [LEN_W-1:0] r_ip;
    logic [LEN_W-1:0] r_udp;
    logic             r_v4;
    logic [7:0]       r_ttl_old;
    logic [7:0]       r_l4;
    logic [15:0]      r_ipcs;
    logic [15:0]      r_ucs;
    logic [15:0]      r_flags_old;
    logic [15:0]      r_flags_new;
    logic [15:0]      r_ucs_new;
    logic [15:0]      r_ipcs_new;
    logic [1:0]       r_verdict;
    logic [CNT_W-1:0] r_j;
    t_word            r_tap [5];

    logic             r_ov;
    logic [63:0]      r_ow;
    logic [3:0]       r_ovb;
    logic             r_olast;
    logic [1:0]       r_overd;

    t_word            rword;
    logic             slot_free;
    logic [ADDR_W-1:0] fw;
    logic [ADDR_W-1:0] fw_next;
    logic [127:0]     fpair;
    logic [63:0]      fb;
    logic [SUM_W-1:0] lenx, offx, ipx, udpx;
    logic             is_tag;
    logic [3:0]       ihl;
    logic             emit;
    logic [CNT_W-1:0] oi;
    logic [CNT_W-1:0] rd_idx;
    t_word            nt [5];
    logic [7:0]       bb [40];
    logic [63:0]      new_word;
    logic [SUM_W-1:0] gb;

    assign rword     = t_word'(i_ram_rdata);
    assign slot_free = !r_ov || !i_out_stall;
    assign lenx      = SUM_W'(r_len);
    assign offx      = SUM_W'(r_off);
    assign ipx       = SUM_W'(r_ip);
    assign udpx      = SUM_W'(r_udp);
    assign is_tag    = (r_proto == ET_VLAN) || (r_proto == ET_QINQ);

    // Field fetch: two neighbor words, eight bytes from the byte offset
    assign fw      = r_faddr[ADDR_W+2:3];
    assign fw_next = (fw == ADDR_W'(HDR_WORDS - 1)) ? fw : fw + ADDR_W'(1);
    assign fpair   = {r_flo, rword.data} << {r_faddr[2:0], 3'b000};
    assign fb      = fpair[127:64];
    assign ihl     = fb[59:56];

    // Output side: word index and tap line after the shift
    assign emit   = (r_j >= CNT_W'(2));
    assign oi     = r_j - CNT_W'(2);
    assign rd_idx = (r_j >= r_n) ? r_n - CNT_W'(1) : r_j;
    assign gb     = SUM_W'({oi, 3'b000});

    always_comb begin
        for (int w = 0; w < 4; w++) begin
            nt[w] = r_tap[w + 1];
        end
        nt[4] = rword;
        for (int w = 0; w < 5; w++) begin
            for (int k = 0; k < 8; k++) begin
                bb[w * 8 + k] = nt[w].data[63 - 8 * k -: 8];
            end
        end
    end

    // Per-lane rewrite of the center word
    always_comb begin
        logic [SUM_W-1:0] g;
        logic [7:0]       b;
        new_word = '0;
        for (int k = 0; k < 8; k++) begin
            g = gb + SUM_W'(k);
            b = bb[16 + k];
            if (r_verdict == V_TX) begin
                if (g < SUM_W'(6)) begin
                    b = bb[22 + k];
                end else if (g < SUM_W'(12)) begin
                    b = bb[10 + k];
                end else if (r_v4 && g >= ipx + SUM_W'(12) && g < ipx + SUM_W'(16)) begin
                    b = bb[20 + k];
                end else if (r_v4 && g >= ipx + SUM_W'(16) && g < ipx + SUM_W'(20)) begin
                    b = bb[12 + k];
                end else if (r_v4 && g == ipx + SUM_W'(8)) begin
                    b = i_reply_ttl;
                end else if (r_v4 && g == ipx + SUM_W'(10)) begin
                    b = r_ipcs_new[15:8];
                end else if (r_v4 && g == ipx + SUM_W'(11)) begin
                    b = r_ipcs_new[7:0];
                end else if (!r_v4 && g >= ipx + SUM_W'(8) && g < ipx + SUM_W'(24)) begin
                    b = bb[32 + k];
                end else if (!r_v4 && g >= ipx + SUM_W'(24) && g < ipx + SUM_W'(40)) begin
                    b = bb[k];
                end else if (!r_v4 && g == ipx + SUM_W'(7)) begin
                    b = i_reply_ttl;
                end else if (g >= udpx && g < udpx + SUM_W'(2)) begin
                    b = bb[18 + k];
                end else if (g >= udpx + SUM_W'(2) && g < udpx + SUM_W'(4)) begin
                    b = bb[14 + k];
                end else if (g == udpx + SUM_W'(6)) begin
                    b = r_ucs_new[15:8];
                end else if (g == udpx + SUM_W'(7)) begin
                    b = r_ucs_new[7:0];
                end else if (g == udpx + SUM_W'(10)) begin
                    b = r_flags_new[15:8];
                end else if (g == udpx + SUM_W'(11)) begin
                    b = r_flags_new[7:0];
                end
            end
            new_word[63 - 8 * k -: 8] = b;
        end
    end

    // RAM read port and queue pop
    always_comb begin
        o_ram_ren   = 1'b0;
        o_ram_raddr = fw;
        o_q_pop     = 1'b0;
        o_win_done  = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                o_q_pop = !i_q_empty && (i_q_cmd.win || slot_free);
            end
            B_FRD0: begin
                o_ram_ren = 1'b1;
            end
            B_FRD1: begin
                o_ram_ren   = 1'b1;
                o_ram_raddr = fw_next;
            end
            B_ORD: begin
                o_ram_ren   = 1'b1;
                o_ram_raddr = rd_idx[ADDR_W-1:0];
            end
            B_OSH: begin
                o_win_done = !(emit && !slot_free) && (r_j == r_n + CNT_W'(1));
            end
            default: begin
            end
        endcase
    end

    // Parse and output sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_verdict <= V_DROP;
            r_ov      <= 1'b0;
        end else begin
            if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            r_state <= n_state;
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        if (i_q_cmd.win) begin
                            r_n    <= i_q_cmd.n;
                            r_len  <= i_q_cmd.len;
                            r_last <= i_q_cmd.last;
                            r_v4   <= 1'b0;
                            r_j    <= '0;
                            if (i_q_cmd.len < LEN_W'(14)) begin
                                r_verdict <= V_DROP;
                            end else begin
                                r_faddr <= LEN_W'(12);
                                r_step  <= ST_ETYPE;
                            end
                        end else if (slot_free) begin
                            r_ov     <= 1'b1;
                            r_ow     <= i_q_cmd.word;
                            r_ovb    <= i_q_cmd.vb;
                            r_olast  <= i_q_cmd.last;
                            r_overd  <= r_verdict;
                        end
                    end
                end
                B_FRD1: begin
                    r_flo <= rword.data;
                end
                B_FEVAL: begin
                    case (r_step)
                        ST_ETYPE: begin
                            r_proto <= fb[63:48];
                            r_off   <= LEN_W'(14);
                            r_tags  <= '0;
                        end
                        ST_TAG: begin
                            r_proto <= fb[63:48];
                            r_off   <= r_off + LEN_W'(4);
                            r_tags  <= r_tags + TAG_W'(1);
                        end
                        ST_V4A: begin
                            if (ihl < 4'd5) begin
                                r_verdict <= V_PASS;
                            end else begin
                                r_udp   <= r_ip + LEN_W'({ihl, 2'b00});
                                r_faddr <= r_ip + LEN_W'(8);
                                r_step  <= ST_V4B;
                            end
                        end
                        ST_V4B: begin
                            r_ttl_old <= fb[63:56];
                            r_l4      <= fb[55:48];
                            r_ipcs    <= fb[47:32];
                            r_v4      <= 1'b1;
                        end
                        ST_V6: begin
                            r_l4  <= fb[63:56];
                            r_udp <= r_ip + LEN_W'(40);
                        end
                        ST_UDP: begin
                            if (fb[63:48] != i_match_port) begin
                                r_verdict <= V_PASS;
                            end else if (udpx + SUM_W'(20) > lenx) begin
                                r_verdict <= V_PASS;
                            end else begin
                                r_ucs   <= fb[31:16];
                                r_faddr <= r_udp + LEN_W'(10);
                                r_step  <= ST_DNS;
                            end
                        end
                        default: begin
                            r_flags_old <= fb[63:48];
                            r_flags_new <= {(fb[63:56] & 8'h01) | 8'h82, fb[55:48] | 8'h80};
                        end
                    endcase
                end
                B_ROUTE: begin
                    if (is_tag && r_tags < TAG_W'(MAX_VLAN_TAGS)) begin
                        if (offx + SUM_W'(4) > lenx) begin
                            r_verdict <= V_DROP;
                        end else begin
                            r_faddr <= r_off + LEN_W'(2);
                            r_step  <= ST_TAG;
                        end
                    end else if (r_proto == ET_IPV4) begin
                        r_ip <= r_off;
                        if (offx + SUM_W'(20) > lenx) begin
                            r_verdict <= V_DROP;
                        end else begin
                            r_faddr <= r_off;
                            r_step  <= ST_V4A;
                        end
                    end else if (r_proto == ET_IPV6) begin
                        r_ip <= r_off;
                        if (offx + SUM_W'(40) > lenx) begin
                            r_verdict <= V_DROP;
                        end else begin
                            r_faddr <= r_off + LEN_W'(6);
                            r_step  <= ST_V6;
                        end
                    end else begin
                        r_verdict <= V_PASS;
                    end
                end
                B_L4: begin
                    if (r_l4 != IP_UDP) begin
                        r_verdict <= V_PASS;
                    end else if (udpx + SUM_W'(8) > lenx) begin
                        r_verdict <= V_DROP;
                    end else begin
                        r_faddr <= r_udp + LEN_W'(2);
                        r_step  <= ST_UDP;
                    end
                end
                B_CS: begin
                    r_ucs_new  <= csum_patch(r_ucs, r_flags_old, r_flags_new);
                    r_ipcs_new <= csum_patch(r_ipcs, {r_ttl_old, r_l4}, {i_reply_ttl, r_l4});
                    r_verdict  <= V_TX;
                end
                B_OSH: begin
                    if (!(emit && !slot_free)) begin
                        for (int w = 0; w < 5; w++) begin
                            r_tap[w] <= nt[w];
                        end
                        if (emit) begin
                            r_ov    <= 1'b1;
                            r_ow    <= new_word;
                            r_ovb   <= nt[2].vb;
                            r_olast <= r_last && (oi == r_n - CNT_W'(1));
                            r_overd <= r_verdict;
                        end
                        r_j <= r_j + CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty && i_q_cmd.win) begin
                    n_state = (i_q_cmd.len < LEN_W'(14)) ? B_ORD : B_FRD0;
                end
            end
            B_FRD0: n_state = B_FRD1;
            B_FRD1: n_state = B_FEVAL;
            B_FEVAL: begin
                case (r_step)
                    ST_ETYPE, ST_TAG: n_state = B_ROUTE;
                    ST_V4A:  n_state = (ihl < 4'd5) ? B_ORD : B_FRD0;
                    ST_V4B, ST_V6: n_state = B_L4;
                    ST_UDP: begin
                        if (fb[63:48] != i_match_port || udpx + SUM_W'(20) > lenx) begin
                            n_state = B_ORD;
                        end else begin
                            n_state = B_FRD0;
                        end
                    end
                    default: n_state = B_CS;
                endcase
            end
            B_ROUTE: begin
                if (is_tag && r_tags < TAG_W'(MAX_VLAN_TAGS)) begin
                    n_state = (offx + SUM_W'(4) > lenx) ? B_ORD : B_FRD0;
                end else if (r_proto == ET_IPV4) begin
                    n_state = (offx + SUM_W'(20) > lenx) ? B_ORD : B_FRD0;
                end else if (r_proto == ET_IPV6) begin
                    n_state = (offx + SUM_W'(40) > lenx) ? B_ORD : B_FRD0;
                end else begin
                    n_state = B_ORD;
                end
            end
            B_L4: begin
                if (r_l4 != IP_UDP || udpx + SUM_W'(8) > lenx) begin
                    n_state = B_ORD;
                end else begin
                    n_state = B_FRD0;
                end
            end
            B_CS:  n_state = B_ORD;
            B_ORD: n_state = B_OSH;
            B_OSH: begin
                if (!(emit && !slot_free)) begin
                    n_state = (r_j == r_n + CNT_W'(1)) ? B_IDLE : B_ORD;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign o_out_valid       = r_ov;
    assign o_out_word        = r_ow;
    assign o_out_valid_bytes = r_ovb;
    assign o_out_last        = r_olast;
    assign o_verdict         = r_overd;

endmodule

`default_nettype wire

// ----- hw/rtl/dns_truncation_reflector.sv -----
// Top level of the DNS truncation reflector.
//
// Packet words enter on the input channel and up to HDR_WORDS of them are held in a
// header buffer until the packet ends or the buffer is full. The window is then
// parsed (Ethernet, VLAN tags, IPv4/IPv6, UDP) by a fetch sequencer that reads two
// buffer words per field; matching DNS queries are rewritten into truncated replies
// while the window is streamed out, each word read in B_ORD and sent from B_OSH, every
// word carrying the verdict (0 drop, 1 pass, 2 transmit). Words after a full window
// pass at one word per cycle, unless the output stalls, with the held verdict.
// Buffering of the next packet's header waits until the previous window has been
// sent. Registers: index 0 is the UDP port answered (reset 53), index 1 the TTL or
// hop limit written into replies (reset 64).
`default_nettype none

module dns_truncation_reflector import drt_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [63:0]          i_word_bytes,
    input  wire logic [3:0]           i_valid_bytes,
    input  wire logic                 i_last_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [63:0]               o_out_word,
    output logic [3:0]                o_out_valid_bytes,
    output logic                      o_out_last,
    output logic [1:0]                o_verdict,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);

    logic [15:0]       r_match_port;
    logic [7:0]        r_reply_ttl;
    logic              q_push, q_pop, q_full, q_empty;
    t_cmd              q_in, q_out;
    logic              ram_we, ram_ren;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [RAM_W-1:0]  ram_wdata, ram_rdata;
    logic              win_done;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_port <= MATCH_PORT_RST;
            r_reply_ttl  <= REPLY_TTL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MATCH_PORT: r_match_port <= i_cfg_data;
                CFG_REPLY_TTL:  r_reply_ttl  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    drt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_word_bytes (i_word_bytes),
        .i_valid_bytes(i_valid_bytes),
        .i_last_word  (i_last_word),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_in),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .i_win_done   (win_done)
    );

    drt_ram #(
        .WIDTH(RAM_W),
        .DEPTH(HDR_WORDS)
    ) u_hdr_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_ren  (ram_ren),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    drt_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_cmd  (q_out),
        .o_empty(q_empty)
    );

    drt_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_cmd          (q_out),
        .i_q_empty        (q_empty),
        .o_q_pop          (q_pop),
        .o_ram_ren        (ram_ren),
        .o_ram_raddr      (ram_raddr),
        .i_ram_rdata      (ram_rdata),
        .i_match_port     (r_match_port),
        .i_reply_ttl      (r_reply_ttl),
        .o_win_done       (win_done),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_word       (o_out_word),
        .o_out_valid_bytes(o_out_valid_bytes),
        .o_out_last       (o_out_last),
        .o_verdict        (o_verdict)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/drt_checker.sv -----
// Port-level checks for the DNS truncation reflector, bound to the top level.
`default_nettype none

module drt_checker import drt_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic [63:0]          i_word_bytes,
    input wire logic [3:0]           i_valid_bytes,
    input wire logic                 i_last_word,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [63:0]          o_out_word,
    input wire logic [3:0]           o_out_valid_bytes,
    input wire logic                 o_out_last,
    input wire logic [1:0]           o_verdict,
    input wire logic                 i_cfg_valid,
    input wire logic                 o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input wire logic [15:0]          i_cfg_data
);

    // A stalled result transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    // Every result carries a defined verdict
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_verdict == V_DROP || o_verdict == V_PASS || o_verdict == V_TX))
        else $error("undefined verdict");

    // Valid byte count is always normalized
    a_vb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_valid_bytes != 4'd0 && o_out_valid_bytes <= 4'd8))
        else $error("output valid byte count out of range");

    // Reset empties the output stage
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind dns_truncation_reflector drt_checker u_drt_checker (.*);

`default_nettype wire

// ----- bench/dns_truncation_reflector_tb.sv -----
// Self-checking testbench for the DNS truncation reflector top level.
`timescale 1ns / 100ps

module dns_truncation_reflector_tb;
    import drt_pkg::*;

    // Output beat as the block should deliver it
    typedef struct {
        logic [63:0] word;
        logic [3:0]  vb;
        logic        last;
        logic [1:0]  verdict;
    } beat_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [63:0]          i_word_bytes;
    logic [3:0]           i_valid_bytes;
    logic                 i_last_word;
    logic                 o_out_valid;
    logic                 out_stall = 1'b0;
    logic [63:0]          o_out_word;
    logic [3:0]           o_out_valid_bytes;
    logic                 o_out_last;
    logic [1:0]           o_verdict;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    dns_truncation_reflector dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_word_bytes      (i_word_bytes),
        .i_valid_bytes     (i_valid_bytes),
        .i_last_word       (i_last_word),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_out_word        (o_out_word),
        .o_out_valid_bytes (o_out_valid_bytes),
        .o_out_last        (o_out_last),
        .o_verdict         (o_verdict),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Shadow of the block: window, counts, verdict, registers
    logic [63:0] win_word [0:HDR_WORDS-1];
    logic [3:0]  win_vb   [0:HDR_WORDS-1];
    int          win_count;
    logic [1:0]  pkt_verdict;
    logic [15:0] dns_port;
    logic [7:0]  ttl_value;
    logic [7:0]  hdr [0:HDR_WORDS*8-1];

    beat_t       expected_beats[$];
    logic [7:0]  pkt_q[$];
    int          words_sent;
    int          errors;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_go;
    logic        rx_hold = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("** dns_truncation_reflector: FAILED **");
        $finish;
    end

    // Header byte helpers
    function automatic logic [15:0] get16(input int p);
        return {hdr[p], hdr[p+1]};
    endfunction

    function automatic void put16(input int p, input logic [15:0] v);
        hdr[p]   = v[15:8];
        hdr[p+1] = v[7:0];
    endfunction

    function automatic void swap_bytes(input int a, input int b, input int n);
        logic [7:0] t [16];
        for (int i = 0; i < n; i++) t[i] = hdr[a+i];
        for (int i = 0; i < n; i++) hdr[a+i] = hdr[b+i];
        for (int i = 0; i < n; i++) hdr[b+i] = t[i];
    endfunction

    // Incremental ones-complement checksum fix-up
    function automatic void fix_sum(input int p, input logic [15:0] from,
                                    input logic [15:0] to);
        logic [31:0] c;
        logic [31:0] f;
        logic [31:0] r;
        logic [31:0] r2;
        c = ~{16'h0, get16(p)};
        f = ~{16'h0, from};
        r = c + f;
        if (r < f) r = r + 1;
        r2 = r + {16'h0, to};
        if (r2 < {16'h0, to}) r2 = r2 + 1;
        r2 = (r2 & 32'hffff) + (r2 >> 16);
        r2 = (r2 & 32'hffff) + (r2 >> 16);
        put16(p, ~r2[15:0]);
    endfunction

    // Parse the held window, rewrite it on a match, return the verdict
    function automatic logic [1:0] judge_window(input int n);
        int          len;
        int          off;
        int          ip_off;
        int          ihl;
        int          udp;
        int          dns;
        bit          v4;
        logic [15:0] pr;
        logic [15:0] old_w;
        for (int i = 0; i < n; i++)
            for (int k = 0; k < 8; k++) hdr[i*8+k] = win_word[i][63-8*k -: 8];
        len = 0;
        for (int i = 0; i < n; i++) begin
            len += win_vb[i];
            if (win_vb[i] < 8) break;
        end
        if (len < 14) return V_DROP;
        pr  = get16(12);
        off = 14;
        for (int i = 0; i < MAX_VLAN_TAGS; i++) begin
            if (pr != ET_VLAN && pr != ET_QINQ) break;
            if (off + 4 > len) return V_DROP;
            pr = get16(off + 2);
            off += 4;
        end
        ip_off = off;
        if (pr == ET_IPV4) begin
            if (off + 20 > len) return V_DROP;
            ihl = hdr[off][3:0];
            if (ihl < 5) return V_PASS;
            pr = {8'h0, hdr[off+9]};
            off += ihl * 4;
            v4 = 1'b1;
        end else if (pr == ET_IPV6) begin
            if (off + 40 > len) return V_DROP;
            pr = {8'h0, hdr[off+6]};
            off += 40;
            v4 = 1'b0;
        end else begin
            return V_PASS;
        end
        if (pr != {8'h0, IP_UDP}) return V_PASS;
        if (off + 8 > len) return V_DROP;
        if (get16(off + 2) != dns_port) return V_PASS;
        if (off + 20 > len) return V_PASS;
        // DNS flags: QR, TC, RA set; opcode and AA cleared
        udp = off;
        dns = off + 8;
        old_w = get16(dns + 2);
        hdr[dns+2] = (hdr[dns+2] & 8'h01) | 8'h82;
        hdr[dns+3] = hdr[dns+3] | 8'h80;
        fix_sum(udp + 6, old_w, get16(dns + 2));
        swap_bytes(0, 6, 6);
        if (v4) begin
            old_w = get16(ip_off + 8);
            swap_bytes(ip_off + 12, ip_off + 16, 4);
            hdr[ip_off+8] = ttl_value;
            fix_sum(ip_off + 10, old_w, get16(ip_off + 8));
        end else begin
            swap_bytes(ip_off + 8, ip_off + 24, 16);
            hdr[ip_off+7] = ttl_value;
        end
        swap_bytes(udp, udp + 2, 2);
        for (int i = 0; i < n; i++)
            for (int k = 0; k < 8; k++) win_word[i][63-8*k -: 8] = hdr[i*8+k];
        return V_TX;
    endfunction

    // Advance the shadow by one accepted word, queueing the beats it releases
    function automatic void predict_word(input logic [63:0] w, input logic [3:0] vb_in,
                                         input logic last);
        logic [3:0] vb;
        beat_t      b;
        int         n;
        vb = (vb_in == 0) ? 4'd1 : (vb_in > 8) ? 4'd8 : vb_in;
        if (win_count >= HDR_WORDS) begin
            b = '{w, vb, last, pkt_verdict};
            expected_beats.push_back(b);
            if (last) win_count = 0;
            return;
        end
        win_word[win_count] = w;
        win_vb[win_count]   = vb;
        win_count++;
        if (!last && win_count < HDR_WORDS) return;
        n = win_count;
        pkt_verdict = judge_window(n);
        for (int i = 0; i < n; i++) begin
            b = '{win_word[i], win_vb[i], last && (i == n - 1), pkt_verdict};
            expected_beats.push_back(b);
        end
        if (last) win_count = 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    endtask

    // Output side: random stall plus the long hold-off, and the checker
    always @(posedge i_clk) begin
        beat_t e;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected transaction", o_out_word, 64'h0);
            end else begin
                e = expected_beats.pop_front();
                if (o_out_word !== e.word) report_mismatch("word", o_out_word, e.word);
                if (o_out_valid_bytes !== e.vb)
                    report_mismatch("valid bytes", o_out_valid_bytes, e.vb);
                if (o_out_last !== e.last) report_mismatch("last", o_out_last, e.last);
                if (o_verdict !== e.verdict)
                    report_mismatch("verdict", o_verdict, e.verdict);
            end
        end
        out_stall <= rx_hold || ($urandom_range(99) < recv_idle_pct);
    end

    // Long receiver hold-off, counted here
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                rx_hold <= 1'b1;
                repeat (300) @(posedge i_clk);
                rx_hold <= 1'b0;
                hold_go = 1'b0;
            end
        end
    end

    // Offer one word and wait for the transaction
    task automatic send_word(input logic [63:0] w, input logic [3:0] vb, input logic last);
        int idle;
        idle = 0;
        while (idle < 30 && $urandom_range(99) < send_idle_pct) idle++;
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_word_bytes  <= w;
        i_valid_bytes <= vb;
        i_last_word   <= last;
        do @(posedge i_clk); while (o_in_stall);
        predict_word(w, vb, last);
        words_sent++;
    endtask

    // Send pkt_q as words; short_at marks a word sent with a short count
    task automatic send_pkt(input int short_at);
        int          n;
        int          idx;
        logic [63:0] w;
        logic [3:0]  vb;
        n = (pkt_q.size() + 7) / 8;
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 8; k++) begin
                idx = i * 8 + k;
                w[63-8*k -: 8] = (idx < pkt_q.size()) ? pkt_q[idx] : 8'($urandom);
            end
            vb = (pkt_q.size() - i * 8 >= 8) ? 4'd8 : 4'(pkt_q.size() - i * 8);
            if (i == short_at && i < n - 1) vb = 4'($urandom_range(1, 7));
            else if (vb == 8 && $urandom_range(19) == 0) vb = 4'($urandom_range(9, 15));
            else if (vb == 1 && $urandom_range(3) == 0) vb = 4'd0;
            send_word(w, vb, i == n - 1);
        end
    endtask

    // Build a frame: tags, L3 kind (0 v4, 1 v6, else other), UDP, port hit, DNS bytes
    task automatic make_pkt(input int ntags, input int l3, input int ihl, input bit is_udp,
                            input bit hit, input int dns_len, input bit zero_sum);
        logic [15:0] et;
        logic [15:0] port;
        logic [7:0]  pr;
        pkt_q = {};
        repeat (12) pkt_q.push_back(8'($urandom));
        et = (l3 == 0) ? ET_IPV4 : (l3 == 1) ? ET_IPV6 : 16'($urandom);
        for (int t = 0; t < ntags; t++) begin
            port = $urandom_range(1) ? ET_VLAN : ET_QINQ;
            pkt_q.push_back(port[15:8]);
            pkt_q.push_back(port[7:0]);
            repeat (2) pkt_q.push_back(8'($urandom));
        end
        pkt_q.push_back(et[15:8]);
        pkt_q.push_back(et[7:0]);
        if (l3 > 1) begin
            repeat (dns_len + 20) pkt_q.push_back(8'($urandom));
            return;
        end
        pr = IP_UDP;
        if (!is_udp) begin
            do pr = 8'($urandom); while (pr == IP_UDP);
        end
        if (l3 == 0) begin
            pkt_q.push_back({4'h4, 4'(ihl)});
            repeat (8) pkt_q.push_back(8'($urandom));
            pkt_q.push_back(pr);
            repeat (10) pkt_q.push_back(8'($urandom));
            if (ihl > 5) repeat ((ihl - 5) * 4) pkt_q.push_back(8'($urandom));
        end else begin
            pkt_q.push_back({4'h6, 4'($urandom)});
            repeat (5) pkt_q.push_back(8'($urandom));
            pkt_q.push_back(pr);
            repeat (33) pkt_q.push_back(8'($urandom));
        end
        port = hit ? dns_port : dns_port ^ 16'($urandom_range(1, 65535));
        repeat (2) pkt_q.push_back(8'($urandom));
        pkt_q.push_back(port[15:8]);
        pkt_q.push_back(port[7:0]);
        repeat (2) pkt_q.push_back(8'($urandom));
        repeat (2) pkt_q.push_back(zero_sum ? 8'h00 : 8'($urandom));
        repeat (dns_len) pkt_q.push_back(8'($urandom));
    endtask

    // Let the block drain, then go quiet long enough for a register write
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_beats.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_MATCH_PORT) dns_port = data;
        else ttl_value = data[7:0];
    endtask

    // Fields extremes, both IP versions, runts, odd counts, non-IP
    task automatic test_directed();
        make_pkt(0, 0, 5, 1, 1, 12, 1);
        send_pkt(-1);
        make_pkt(0, 1, 5, 1, 1, 12, 0);
        send_pkt(-1);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1);
        send_word(64'h0, 4'd15, 1'b1);
        make_pkt(0, 2, 5, 1, 1, 0, 0);
        pkt_q = pkt_q[0:15];
        send_pkt(-1);
        make_pkt(3, 0, 4, 1, 1, 0, 0);
        pkt_q = pkt_q[0:15];
        send_pkt(-1);
    endtask

    // One random packet, mostly well-formed packets to the matched port with noise mixed in
    task automatic random_pkt();
        int  r;
        int  ntags;
        int  l3;
        int  ihl;
        int  dlen;
        int  short_at;
        r = $urandom_range(99);
        ntags = (r < 50) ? 0 : (r < 75) ? 1 : (r < 92) ? 2 : 3;
        r = $urandom_range(99);
        l3 = (r < 45) ? 0 : (r < 88) ? 1 : 2;
        r = $urandom_range(99);
        ihl = (r < 70) ? 5 : (r < 90) ? $urandom_range(6, 15) : $urandom_range(0, 4);
        r = $urandom_range(99);
        dlen = (r < 75) ? $urandom_range(12, 40) : (r < 90) ? $urandom_range(0, 11)
                                                           : $urandom_range(90, 160);
        make_pkt(ntags, l3, ihl, $urandom_range(9) != 0, $urandom_range(4) != 0, dlen,
                 $urandom_range(9) == 0);
        if ($urandom_range(9) == 0) pkt_q = pkt_q[0:$urandom_range(0, pkt_q.size() - 1)];
        short_at = ($urandom_range(11) == 0) ? $urandom_range(0, 12) : -1;
        send_pkt(short_at);
    endtask

    // Random traffic under one idling pattern and one register setting
    task automatic test_random(input int s_pct, input int r_pct, input logic [15:0] port,
                               input logic [7:0] ttl, input int words);
        int stop_at;
        wait_idle();
        write_reg(CFG_MATCH_PORT, port);
        write_reg(CFG_REPLY_TTL, {8'h0, ttl});
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop_at = words_sent + words;
        while (words_sent < stop_at) random_pkt();
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 1'b1;
        repeat (6) begin
            make_pkt(1, 0, 5, 1, 1, $urandom_range(12, 60), 0);
            send_pkt(-1);
        end
    endtask

    // Sender pauses until every outstanding beat is back
    task automatic test_drain_pause();
        repeat (3) begin
            random_pkt();
            i_in_valid <= 1'b0;
            while (expected_beats.size() > 0) @(posedge i_clk);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_word_bytes  <= '0;
        i_valid_bytes <= 4'd8;
        i_last_word   <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_MATCH_PORT;
        i_cfg_data    <= '0;
        win_count     = 0;
        pkt_verdict   = V_DROP;
        dns_port      = MATCH_PORT_RST;
        ttl_value     = REPLY_TTL_RST;
        words_sent    = 0;
        errors        = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go       = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(12, 57, 16'd0, 8'd0, 80);
        test_random(57, 12, 16'hFFFF, 8'hFF, 80);
        test_random(0, 0, 16'($urandom), 8'($urandom), 80);
        test_backpressure();
        test_drain_pause();

        i_in_valid <= 1'b0;
        while (expected_beats.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("** dns_truncation_reflector: PASSED **");
        else
            $display("** dns_truncation_reflector: FAILED **");
        $finish;
    end

endmodule
